[rtl/core/rrm_pkg.sv]
// Package with the widths, codes, types and limits shared by the running mean block.
`timescale 1ns / 1ps
`default_nettype none

package rrm_pkg;

    localparam int MAX_DIMS     = 8;
    localparam int SAMPLE_WIDTH = 32;
    localparam int FRAC_BITS    = 16;

    localparam int OP_W    = 2;
    localparam int DIM_W   = 3;
    localparam int SMP_W   = SAMPLE_WIDTH;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 4;
    localparam int MEAN_W  = 48;
    localparam int QUOT_W  = MEAN_W + 1;
    localparam int SUM_W   = MEAN_W + 2;
    localparam int CNT_W   = $clog2(QUOT_W + 1);
    localparam int ADDR_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    localparam logic [OP_W-1:0] OP_STREAM = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_SWAP   = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

    localparam logic [CFG_W-1:0] ACTIVE_DIMS_RESET = CFG_W'(1);

    localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W - 1){1'b1}}};
    localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W - 1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic              wr_stream;
        logic              wr_buffer;
        logic [ADDR_W-1:0] addr;
    } t_mem_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

[rtl/core/rrm_req_if.sv]
// Interface for the input channel that carries one update request per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface rrm_req_if;
    logic                                valid;
    logic                                ready;
    logic        [rrm_pkg::OP_W-1:0]    operation;
    logic        [rrm_pkg::DIM_W-1:0]   dim_index;
    logic signed [rrm_pkg::SMP_W-1:0]   new_sample;
    logic signed [rrm_pkg::SMP_W-1:0]   evicted_sample;
    logic        [rrm_pkg::COUNT_W-1:0] sample_count;

    modport source (
        output valid, operation, dim_index, new_sample, evicted_sample, sample_count,
        input  ready
    );

    modport sink (
        input  valid, operation, dim_index, new_sample, evicted_sample, sample_count,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/rrm_rsp_if.sv]
// Interface for the output channel that carries one result per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface rrm_rsp_if;
    logic                               valid;
    logic                               ready;
    logic        [rrm_pkg::DIM_W-1:0]  dim_out;
    logic signed [rrm_pkg::MEAN_W-1:0] stream_mean;
    logic signed [rrm_pkg::MEAN_W-1:0] buffer_mean;
    logic                               error_flag;

    modport source (
        output valid, dim_out, stream_mean, buffer_mean, error_flag,
        input  ready
    );

    modport sink (
        input  valid, dim_out, stream_mean, buffer_mean, error_flag,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/rrm_mean_ram.sv]
// Stream and buffer mean memories with registered reads and per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module rrm_mean_ram (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire rrm_pkg::t_mem_req                  i_req,
    input  wire logic signed [rrm_pkg::MEAN_W-1:0]  i_wr_stream_data,
    input  wire logic signed [rrm_pkg::MEAN_W-1:0]  i_wr_buffer_data,
    output logic signed      [rrm_pkg::MEAN_W-1:0]  o_rd_stream,
    output logic signed      [rrm_pkg::MEAN_W-1:0]  o_rd_buffer
);

    logic signed [rrm_pkg::MEAN_W-1:0] r_stream_mem [rrm_pkg::MAX_DIMS];
    logic signed [rrm_pkg::MEAN_W-1:0] r_buffer_mem [rrm_pkg::MAX_DIMS];
    logic        [rrm_pkg::MAX_DIMS-1:0] r_stream_vld;
    logic        [rrm_pkg::MAX_DIMS-1:0] r_buffer_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_vld <= '0;
            r_buffer_vld <= '0;
        end else begin
            if (i_req.wr_stream) begin
                r_stream_vld[i_req.addr] <= 1'b1;
            end
            if (i_req.wr_buffer) begin
                r_buffer_vld[i_req.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_stream) begin
            r_stream_mem[i_req.addr] <= i_wr_stream_data;
        end
        if (i_req.wr_buffer) begin
            r_buffer_mem[i_req.addr] <= i_wr_buffer_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_stream <= r_stream_vld[i_req.addr] ? r_stream_mem[i_req.addr] : '0;
            o_rd_buffer <= r_buffer_vld[i_req.addr] ? r_buffer_mem[i_req.addr] : '0;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rrm_divider.sv]
// Restoring serial divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rrm_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rrm_pkg::QUOT_W-1:0]    i_dividend,
    input  wire logic [rrm_pkg::COUNT_W-1:0]   i_divisor,
    output rrm_pkg::t_div_stat                 o_stat,
    output logic      [rrm_pkg::QUOT_W-1:0]    o_quotient
);

    logic [rrm_pkg::COUNT_W-1:0] r_rem;
    logic [rrm_pkg::QUOT_W-1:0]  r_acc;
    logic [rrm_pkg::COUNT_W-1:0] r_divisor;
    logic [rrm_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [rrm_pkg::COUNT_W:0]   shifted;
    logic [rrm_pkg::COUNT_W+1:0] trial;
    logic                        q_bit;
    logic [rrm_pkg::COUNT_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_acc[rrm_pkg::QUOT_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_divisor};
        q_bit   = !trial[rrm_pkg::COUNT_W+1];
        n_rem   = q_bit ? trial[rrm_pkg::COUNT_W-1:0] : shifted[rrm_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= rrm_pkg::CNT_W'(rrm_pkg::QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rrm_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_acc     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_acc <= {r_acc[rrm_pkg::QUOT_W-2:0], q_bit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_acc;

endmodule

`default_nettype wire

[rtl/core/reservoir_running_mean.sv]
// Top level of the per-dimension stream and buffer running mean block.
//
//   Channel   Direction  Handshake             Contents
//   i_req     in         valid / ready         operation, dimension, samples, count
//   o_rsp     out        valid / ready         dimension, both means, error flag
//   i_cfg_*   in         write enable only     active dimension count
//
// A stream sample or a buffer swap passes through the memory read, the serial divide and the finish step
// before its result is loaded; the serial divider resolves one of its 49 quotient bits per cycle.
// A buffer add or a rejected transaction skips the divide: one memory read and the finish step.
// Reset is synchronous; the means read as zero until first written.
// The next transaction is accepted while the previous result waits on o_rsp.
`timescale 1ns / 1ps
`default_nettype none

module reservoir_running_mean (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [rrm_pkg::CFG_W-1:0]     i_cfg_wr_data,
    rrm_req_if.sink                            i_req,
    rrm_rsp_if.source                          o_rsp
);

    rrm_pkg::t_state r_state;
    rrm_pkg::t_state n_state;

    logic        [rrm_pkg::CFG_W-1:0]   r_active_dims;
    logic        [rrm_pkg::OP_W-1:0]    r_op;
    logic        [rrm_pkg::DIM_W-1:0]   r_dim;
    logic signed [rrm_pkg::SMP_W-1:0]   r_new;
    logic signed [rrm_pkg::SMP_W-1:0]   r_old;
    logic        [rrm_pkg::COUNT_W-1:0] r_count;
    logic                               r_err;
    logic                               r_in_store;
    logic signed [rrm_pkg::MEAN_W-1:0]  r_ms;
    logic signed [rrm_pkg::MEAN_W-1:0]  r_mb;
    logic                               r_neg;

    logic                               r_out_valid;
    logic        [rrm_pkg::DIM_W-1:0]   r_out_dim;
    logic signed [rrm_pkg::MEAN_W-1:0]  r_out_stream;
    logic signed [rrm_pkg::MEAN_W-1:0]  r_out_buffer;
    logic                               r_out_err;

    rrm_pkg::t_mem_req                  mem_req;
    logic signed [rrm_pkg::MEAN_W-1:0]  mem_rd_stream;
    logic signed [rrm_pkg::MEAN_W-1:0]  mem_rd_buffer;
    logic signed [rrm_pkg::MEAN_W-1:0]  wr_stream_data;
    logic signed [rrm_pkg::MEAN_W-1:0]  wr_buffer_data;

    rrm_pkg::t_div_stat                 div_stat;
    logic                               div_start;
    logic        [rrm_pkg::QUOT_W-1:0]  div_dividend;
    logic        [rrm_pkg::QUOT_W-1:0]  div_quot;

    logic                               accept;
    logic                               in_store;
    logic                               req_err;
    logic                               slot_free;
    logic                               load_out;

    logic signed [rrm_pkg::MEAN_W-1:0]  scaled;
    logic signed [rrm_pkg::MEAN_W:0]    diff_stream;
    logic signed [rrm_pkg::SMP_W:0]     diff_swap;
    logic        [rrm_pkg::MEAN_W:0]    mag_stream;
    logic        [rrm_pkg::SMP_W:0]     mag_swap;
    logic                               n_neg;

    logic signed [rrm_pkg::SUM_W-1:0]   q_eff;
    logic signed [rrm_pkg::SUM_W-1:0]   delta;
    logic signed [rrm_pkg::SUM_W-1:0]   sum;
    logic signed [rrm_pkg::MEAN_W-1:0]  sat_mean;
    logic signed [rrm_pkg::MEAN_W-1:0]  base_mean;

    assign accept    = i_req.valid && i_req.ready;
    assign slot_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        in_store = 32'(i_req.dim_index) < rrm_pkg::MAX_DIMS;
        req_err  = !in_store
                || (rrm_pkg::CFG_W'(i_req.dim_index) >= r_active_dims)
                || (i_req.operation == rrm_pkg::OP_RSVD)
                || ((i_req.operation != rrm_pkg::OP_ADD) && (i_req.sample_count == '0));
    end

    always_comb begin
        scaled      = rrm_pkg::MEAN_W'(r_new) <<< rrm_pkg::FRAC_BITS;
        diff_stream = {scaled[rrm_pkg::MEAN_W-1], scaled}
                    - {mem_rd_stream[rrm_pkg::MEAN_W-1], mem_rd_stream};
        diff_swap   = {r_new[rrm_pkg::SMP_W-1], r_new} - {r_old[rrm_pkg::SMP_W-1], r_old};
        mag_stream  = diff_stream[rrm_pkg::MEAN_W] ? -diff_stream : diff_stream;
        mag_swap    = diff_swap[rrm_pkg::SMP_W] ? -diff_swap : diff_swap;
        if (r_op == rrm_pkg::OP_STREAM) begin
            n_neg        = diff_stream[rrm_pkg::MEAN_W];
            div_dividend = mag_stream;
        end else begin
            n_neg        = diff_swap[rrm_pkg::SMP_W];
            div_dividend = rrm_pkg::QUOT_W'(mag_swap) << rrm_pkg::FRAC_BITS;
        end
    end

    // A swap quotient at or above half the mean range stands for an overflow
    // and is pushed far enough out that the sum saturates.
    always_comb begin
        if ((r_op == rrm_pkg::OP_SWAP)
                && (div_quot[rrm_pkg::QUOT_W-1:rrm_pkg::MEAN_W-1] != '0)) begin
            q_eff = rrm_pkg::SUM_W'(1) <<< rrm_pkg::MEAN_W;
        end else begin
            q_eff = rrm_pkg::SUM_W'(div_quot);
        end
        delta     = r_neg ? -q_eff : q_eff;
        base_mean = (r_op == rrm_pkg::OP_STREAM) ? r_ms : r_mb;
        sum       = rrm_pkg::SUM_W'(base_mean) + delta;
        if (sum > rrm_pkg::SUM_W'(rrm_pkg::MEAN_MAX)) begin
            sat_mean = rrm_pkg::MEAN_MAX;
        end else if (sum < rrm_pkg::SUM_W'(rrm_pkg::MEAN_MIN)) begin
            sat_mean = rrm_pkg::MEAN_MIN;
        end else begin
            sat_mean = sum[rrm_pkg::MEAN_W-1:0];
        end
        wr_stream_data = sat_mean;
        wr_buffer_data = (r_op == rrm_pkg::OP_ADD) ? r_ms : sat_mean;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        i_req.ready       = 1'b0;
        div_start         = 1'b0;
        load_out          = 1'b0;
        mem_req.rd_en     = 1'b0;
        mem_req.wr_stream = 1'b0;
        mem_req.wr_buffer = 1'b0;
        mem_req.addr      = rrm_pkg::ADDR_W'(r_dim);
        unique case (r_state)
            rrm_pkg::ST_IDLE: begin
                i_req.ready   = 1'b1;
                mem_req.addr  = rrm_pkg::ADDR_W'(i_req.dim_index);
                mem_req.rd_en = i_req.valid;
                if (i_req.valid) begin
                    n_state = rrm_pkg::ST_READ;
                end
            end
            rrm_pkg::ST_READ: begin
                if (r_err || (r_op == rrm_pkg::OP_ADD)) begin
                    n_state = rrm_pkg::ST_FINISH;
                end else begin
                    div_start = 1'b1;
                    n_state   = rrm_pkg::ST_DIV;
                end
            end
            rrm_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    n_state = rrm_pkg::ST_FINISH;
                end
            end
            rrm_pkg::ST_FINISH: begin
                if (slot_free) begin
                    load_out          = 1'b1;
                    mem_req.wr_stream = !r_err && (r_op == rrm_pkg::OP_STREAM);
                    mem_req.wr_buffer = !r_err
                                     && ((r_op == rrm_pkg::OP_ADD) || (r_op == rrm_pkg::OP_SWAP));
                    n_state           = rrm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_dims <= rrm_pkg::ACTIVE_DIMS_RESET;
        end else if (i_cfg_wr_en) begin
            r_active_dims <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_req.operation;
            r_dim      <= i_req.dim_index;
            r_new      <= i_req.new_sample;
            r_old      <= i_req.evicted_sample;
            r_count    <= i_req.sample_count;
            r_err      <= req_err;
            r_in_store <= in_store;
        end
        if (r_state == rrm_pkg::ST_READ) begin
            r_ms  <= mem_rd_stream;
            r_mb  <= mem_rd_buffer;
            r_neg <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_dim    <= r_dim;
            r_out_err    <= r_err;
            r_out_stream <= !r_in_store ? '0
                          : (mem_req.wr_stream ? wr_stream_data : r_ms);
            r_out_buffer <= !r_in_store ? '0
                          : (mem_req.wr_buffer ? wr_buffer_data : r_mb);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.dim_out     = r_out_dim;
    assign o_rsp.stream_mean = r_out_stream;
    assign o_rsp.buffer_mean = r_out_buffer;
    assign o_rsp.error_flag  = r_out_err;

    rrm_mean_ram u_mean_ram (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (mem_req),
        .i_wr_stream_data (wr_stream_data),
        .i_wr_buffer_data (wr_buffer_data),
        .o_rd_stream      (mem_rd_stream),
        .o_rd_buffer      (mem_rd_buffer)
    );

    rrm_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_count),
        .o_stat     (div_stat),
        .o_quotient (div_quot)
    );

    a_ready_not_dividing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !div_stat.busy
    ) else $error("Input accepted while the divider is busy.");

    a_write_only_finish: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.wr_stream || mem_req.wr_buffer) |-> (r_state == rrm_pkg::ST_FINISH)
    ) else $error("Mean memory written outside the finish step.");

    a_no_write_on_error: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == rrm_pkg::ST_FINISH) && r_err) |-> !(mem_req.wr_stream || mem_req.wr_buffer)
    ) else $error("Rejected transaction modified the mean memory.");

    a_done_in_div: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == rrm_pkg::ST_DIV)
    ) else $error("Divider finished outside the divide state.");

    a_start_from_read: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (div_stat.busy && (r_state == rrm_pkg::ST_DIV))
    ) else $error("Divider start did not lead to a running division.");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Testbench for reservoir_running_mean: random and directed updates checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic        [rrm_pkg::OP_W-1:0]    op;
        logic        [rrm_pkg::DIM_W-1:0]   dim;
        logic signed [rrm_pkg::SMP_W-1:0]   new_smp;
        logic signed [rrm_pkg::SMP_W-1:0]   old_smp;
        logic        [rrm_pkg::COUNT_W-1:0] count;
    } t_req_item;

    typedef struct packed {
        logic        [rrm_pkg::DIM_W-1:0]  dim;
        logic signed [rrm_pkg::MEAN_W-1:0] stream;
        logic signed [rrm_pkg::MEAN_W-1:0] buffer;
        logic                              err;
    } t_mean_result;

    localparam longint MEAN_HI = (longint'(1) << (rrm_pkg::MEAN_W - 1)) - 1;
    localparam longint MEAN_LO = -MEAN_HI - 1;
    localparam int     ITEMS_PER_PHASE = 200;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        cfg_wr_en;
    logic [rrm_pkg::CFG_W-1:0]   cfg_wr_data;

    rrm_req_if req_bus ();
    rrm_rsp_if rsp_bus ();

    reservoir_running_mean u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_bus),
        .o_rsp         (rsp_bus)
    );

    always #10 i_clk = ~i_clk;

    t_req_item                         pending_q[$];
    t_mean_result                      mean_expect_q[$];
    logic signed [rrm_pkg::MEAN_W-1:0] stream_avg[rrm_pkg::MAX_DIMS];
    logic signed [rrm_pkg::MEAN_W-1:0] buffer_avg[rrm_pkg::MAX_DIMS];
    logic [rrm_pkg::CFG_W-1:0]         active_dims_cfg;
    int unsigned                       mismatch_count;
    int unsigned                       accept_count;
    int unsigned                       seen_accepts;
    int                                burst_left;
    int                                gap_left;
    int                                stall_mode;
    int                                stall_mode_left;
    int unsigned                       stream_len[rrm_pkg::MAX_DIMS];
    int unsigned                       reservoir_fill[rrm_pkg::MAX_DIMS];
    int                                level[rrm_pkg::MAX_DIMS];

    function automatic logic signed [rrm_pkg::MEAN_W-1:0] clamp_mean(input longint v);
        if (v > MEAN_HI) begin
            v = MEAN_HI;
        end else if (v < MEAN_LO) begin
            v = MEAN_LO;
        end
        return v[rrm_pkg::MEAN_W-1:0];
    endfunction

    function automatic t_mean_result apply_update(input t_req_item it);
        t_mean_result res;
        longint       n;
        longint       x_new;
        longint       x_old;
        longint       m;
        longint       diff;
        longint       q;
        longint       r;
        longint       lim;
        longint       step;
        bit           in_store;
        bit           reject;
        n        = longint'({32'b0, it.count});
        x_new    = longint'($signed(it.new_smp));
        x_old    = longint'($signed(it.old_smp));
        lim      = MEAN_HI >>> rrm_pkg::FRAC_BITS;
        in_store = int'(it.dim) < rrm_pkg::MAX_DIMS;
        reject   = !in_store || int'(it.dim) >= int'(active_dims_cfg)
                   || it.op == rrm_pkg::OP_RSVD
                   || (it.op != rrm_pkg::OP_ADD && n == 0);
        if (!reject) begin
            case (it.op)
                rrm_pkg::OP_STREAM: begin
                    m = stream_avg[it.dim];
                    if (x_new > lim) begin
                        step = MEAN_HI;
                    end else if (x_new < -lim - 1) begin
                        step = MEAN_LO;
                    end else begin
                        step = x_new * (longint'(1) << rrm_pkg::FRAC_BITS);
                    end
                    stream_avg[it.dim] = clamp_mean(m + (step - m) / n);
                end
                rrm_pkg::OP_ADD: begin
                    buffer_avg[it.dim] = stream_avg[it.dim];
                end
                rrm_pkg::OP_SWAP: begin
                    m    = buffer_avg[it.dim];
                    diff = x_new - x_old;
                    q    = diff / n;
                    r    = diff % n;
                    if (q > lim) begin
                        step = longint'(1) << rrm_pkg::MEAN_W;
                    end else if (q < -lim) begin
                        step = -(longint'(1) << rrm_pkg::MEAN_W);
                    end else begin
                        step = q * (longint'(1) << rrm_pkg::FRAC_BITS)
                             + (r * (longint'(1) << rrm_pkg::FRAC_BITS)) / n;
                    end
                    buffer_avg[it.dim] = clamp_mean(m + step);
                end
                default: begin
                end
            endcase
        end
        res.dim    = it.dim;
        res.stream = in_store ? stream_avg[it.dim] : '0;
        res.buffer = in_store ? buffer_avg[it.dim] : '0;
        res.err    = reject;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic queue_item(input logic [rrm_pkg::OP_W-1:0] op,
                              input logic [rrm_pkg::DIM_W-1:0] dim,
                              input int new_smp, input int old_smp, input int unsigned count);
        t_req_item it;
        it.op      = op;
        it.dim     = dim;
        it.new_smp = new_smp;
        it.old_smp = old_smp;
        it.count   = count;
        pending_q.push_back(it);
    endtask

    task automatic wait_for_idle(input int settle);
        while (pending_q.size() != 0 || mean_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic set_active_dims(input logic [rrm_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        active_dims_cfg = value;
    endtask

    // Most items follow a plausible stream per dimension; the rest are random noise.
    function automatic t_req_item make_item();
        t_req_item   it;
        int unsigned pick;
        int          dim_lim;
        it.op      = rrm_pkg::OP_W'($urandom_range(0, 3));
        it.dim     = rrm_pkg::DIM_W'($urandom);
        it.new_smp = $urandom;
        it.old_smp = $urandom;
        it.count   = $urandom;
        if ($urandom_range(0, 9) < 3) begin
            return it;
        end
        dim_lim = (active_dims_cfg == 0) ? rrm_pkg::MAX_DIMS
                : (int'(active_dims_cfg) > rrm_pkg::MAX_DIMS) ? rrm_pkg::MAX_DIMS
                : int'(active_dims_cfg);
        it.dim = rrm_pkg::DIM_W'($urandom_range(0, dim_lim - 1));
        if ($urandom_range(0, 19) != 0) begin
            it.new_smp = level[it.dim] + int'($urandom_range(0, 4000)) - 2000;
            it.old_smp = level[it.dim] + int'($urandom_range(0, 4000)) - 2000;
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            it.op = rrm_pkg::OP_STREAM;
            stream_len[it.dim]++;
            it.count = stream_len[it.dim];
        end else if (pick < 7) begin
            it.op = rrm_pkg::OP_ADD;
            reservoir_fill[it.dim] = (stream_len[it.dim] > 16) ? 16 : stream_len[it.dim];
        end else begin
            it.op    = rrm_pkg::OP_SWAP;
            it.count = (reservoir_fill[it.dim] == 0) ? $urandom_range(1, 16)
                                                     : reservoir_fill[it.dim];
        end
        return it;
    endfunction

    // The predictor runs on every accepted request transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && req_bus.valid && req_bus.ready) begin
            mean_expect_q.push_back(apply_update(pending_q.pop_front()));
            accept_count++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (req_bus.valid && accept_count == seen_accepts) begin
        end else begin
            seen_accepts = accept_count;
            if (gap_left != 0) begin
                gap_left--;
                req_bus.valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                req_bus.valid          <= 1'b1;
                req_bus.operation      <= pending_q[0].op;
                req_bus.dim_index      <= pending_q[0].dim;
                req_bus.new_sample     <= pending_q[0].new_smp;
                req_bus.evicted_sample <= pending_q[0].old_smp;
                req_bus.sample_count   <= pending_q[0].count;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 80) : 0;
                end else begin
                    burst_left--;
                end
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 300);
        end else begin
            stall_mode_left--;
        end
        case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_bus.ready <= ~rsp_bus.ready;
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_mean_result want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (mean_expect_q.size() == 0) begin
                report_mismatch("unrequested result, dim_out", longint'(rsp_bus.dim_out), -1);
            end else begin
                want = mean_expect_q.pop_front();
                if (rsp_bus.dim_out !== want.dim) begin
                    report_mismatch("dim_out", longint'(rsp_bus.dim_out), longint'(want.dim));
                end
                if (rsp_bus.stream_mean !== want.stream) begin
                    report_mismatch("stream_mean", longint'($signed(rsp_bus.stream_mean)),
                                    longint'($signed(want.stream)));
                end
                if (rsp_bus.buffer_mean !== want.buffer) begin
                    report_mismatch("buffer_mean", longint'($signed(rsp_bus.buffer_mean)),
                                    longint'($signed(want.buffer)));
                end
                if (rsp_bus.error_flag !== want.err) begin
                    report_mismatch("error_flag", longint'(rsp_bus.error_flag),
                                    longint'(want.err));
                end
            end
        end
    end

    initial begin
        logic [rrm_pkg::CFG_W-1:0] dims_plan[7];
        i_rst_n                = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        req_bus.valid          = 1'b0;
        req_bus.operation      = rrm_pkg::OP_STREAM;
        req_bus.dim_index      = '0;
        req_bus.new_sample     = '0;
        req_bus.evicted_sample = '0;
        req_bus.sample_count   = '0;
        rsp_bus.ready          = 1'b0;
        active_dims_cfg        = rrm_pkg::ACTIVE_DIMS_RESET;
        mismatch_count         = 0;
        accept_count           = 0;
        seen_accepts           = 0;
        burst_left             = 1;
        gap_left               = 0;
        stall_mode             = 0;
        stall_mode_left        = 0;
        for (int d = 0; d < rrm_pkg::MAX_DIMS; d++) begin
            stream_avg[d]     = '0;
            buffer_avg[d]     = '0;
            stream_len[d]     = 0;
            reservoir_fill[d] = 0;
            level[d]          = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Only dimension 0 is active after reset.
        queue_item(rrm_pkg::OP_STREAM, 0, 32'h7fff_ffff, 0, 1);
        queue_item(rrm_pkg::OP_STREAM, 0, 32'h8000_0000, 0, 2);
        queue_item(rrm_pkg::OP_STREAM, 1, 100, 0, 1);
        queue_item(rrm_pkg::OP_STREAM, 0, 100, 0, 0);
        queue_item(rrm_pkg::OP_RSVD, 0, 100, 7, 1);
        queue_item(rrm_pkg::OP_ADD, 0, 0, 0, 0);
        queue_item(rrm_pkg::OP_SWAP, 0, 32'h7fff_ffff, 32'h8000_0000, 1);
        queue_item(rrm_pkg::OP_SWAP, 0, 32'h7fff_ffff, 32'h8000_0000, 1);
        queue_item(rrm_pkg::OP_SWAP, 0, 32'h8000_0000, 32'h7fff_ffff, 1);
        queue_item(rrm_pkg::OP_SWAP, 0, 5, -3, 0);
        queue_item(rrm_pkg::OP_SWAP, 0, 5, -3, 32'hffff_ffff);
        queue_item(rrm_pkg::OP_STREAM, 0, -7, 0, 32'hffff_ffff);
        queue_item(rrm_pkg::OP_STREAM, 0, 3, 0, 3);
        wait_for_idle(8);
        set_active_dims(rrm_pkg::CFG_W'(rrm_pkg::MAX_DIMS));
        for (int d = 0; d < rrm_pkg::MAX_DIMS; d++) begin
            queue_item(rrm_pkg::OP_STREAM, rrm_pkg::DIM_W'(d),
                       (d % 2) ? -(d * 1000 + 1) : d * 777, 0, d + 1);
        end
        queue_item(rrm_pkg::OP_ADD, 7, 0, 0, 32'hffff_ffff);
        queue_item(rrm_pkg::OP_SWAP, 7, -1, 0, 3);
        wait_for_idle(8);
        set_active_dims(0);
        queue_item(rrm_pkg::OP_ADD, 0, 0, 0, 1);
        queue_item(rrm_pkg::OP_STREAM, 0, 1, 0, 1);

        dims_plan = '{4'd8, 4'd15, 4'd3, 4'd1, 4'd5, 4'd2, 4'd0};
        dims_plan[6] = rrm_pkg::CFG_W'($urandom_range(1, 8));
        foreach (dims_plan[p]) begin
            wait_for_idle(8);
            set_active_dims(dims_plan[p]);
            for (int d = 0; d < rrm_pkg::MAX_DIMS; d++) begin
                level[d] = int'($urandom_range(0, 200000)) - 100000;
            end
            repeat (ITEMS_PER_PHASE) pending_q.push_back(make_item());
        end

        wait_for_idle(60);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[reservoir_running_mean.f]
rtl/core/rrm_pkg.sv
rtl/core/rrm_req_if.sv
rtl/core/rrm_rsp_if.sv
rtl/core/rrm_mean_ram.sv
rtl/core/rrm_divider.sv
rtl/core/reservoir_running_mean.sv
bench/tb_top.sv
